// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define CAU_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// Antecedent implies consequent at the same edge.
`define CAU_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication failed");

`endif

// ----- rtl/cau_pkg.sv -----
package cau_pkg;

    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    typedef struct packed {
        logic valid;
        logic is_div;
        logic dz;
    } ctl_t;

endpackage

// ----- rtl/cau_in_if.sv -----
interface cau_in_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic signed [DATA_WIDTH-1:0] a_real;
    logic signed [DATA_WIDTH-1:0] a_imag;
    logic signed [DATA_WIDTH-1:0] b_real;
    logic signed [DATA_WIDTH-1:0] b_imag;

    modport source (output valid, func, a_real, a_imag, b_real, b_imag, input ready);
    modport sink (input valid, func, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// ----- rtl/cau_out_if.sv -----
interface cau_out_if #(
    parameter int DATA_WIDTH = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] res_real;
    logic signed [DATA_WIDTH-1:0] res_imag;
    logic                         overflow;
    logic                         div_by_zero;

    modport source (output valid, res_real, res_imag, overflow, div_by_zero, input ready);
    modport sink (input valid, res_real, res_imag, overflow, div_by_zero, output ready);
endinterface

// ----- rtl/cau_front.sv -----
module cau_front #(
    parameter int W = 16,
    parameter int F = 12,
    localparam int NW = 2*W + 1 + F
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  logic [1:0]            func,
    input  logic signed [W-1:0]   a_real,
    input  logic signed [W-1:0]   a_imag,
    input  logic signed [W-1:0]   b_real,
    input  logic signed [W-1:0]   b_imag,
    output cau_pkg::ctl_t         ctl,
    output logic [1:0]            neg,
    output logic [1:0][W:0]       val,
    output logic [1:0][NW-1:0]    rem,
    output logic [2*W:0]          den
);
    import cau_pkg::*;

    localparam int PW  = 2*W;
    localparam int SW  = W + 1;
    localparam int SSW = 2*W + 1;

    // stage 1: products, squares, part-wise sums
    logic                 v1_reg;
    logic [1:0]           func1_reg;
    logic                 bz1_reg;
    logic signed [PW-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [PW-1:0] sq_r_reg, sq_i_reg;
    logic signed [SW-1:0] s_re_reg, s_im_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            func1_reg <= func;
            bz1_reg   <= (b_real == '0) && (b_imag == '0);
            p_rr_reg  <= PW'(a_real) * PW'(b_real);
            p_ii_reg  <= PW'(a_imag) * PW'(b_imag);
            p_ri_reg  <= PW'(a_real) * PW'(b_imag);
            p_ir_reg  <= PW'(a_imag) * PW'(b_real);
            sq_r_reg  <= PW'(b_real) * PW'(b_real);
            sq_i_reg  <= PW'(b_imag) * PW'(b_imag);
            if (func == FUNC_SUB)
            begin
                s_re_reg <= SW'(a_real) - SW'(b_real);
                s_im_reg <= SW'(a_imag) - SW'(b_imag);
            end
            else
            begin
                s_re_reg <= SW'(a_real) + SW'(b_real);
                s_im_reg <= SW'(a_imag) + SW'(b_imag);
            end
        end
    end

    // stage 2: combine, take magnitude, set up the divider
    function automatic logic [W:0] cap(input logic [SSW-1:0] m);
        if ((m >> W) != '0)
            cap = {1'b1, {W{1'b0}}};
        else
            cap = m[W:0];
    endfunction

    logic signed [SSW-1:0] s_sel [2];
    logic [SSW-1:0]        mag [2];
    logic [SSW-1:0]        den_c;
    ctl_t                  ctl_next;
    logic [1:0]            neg_next;
    logic [1:0][W:0]       val_next;
    logic [1:0][NW-1:0]    rem_next;

    ctl_t               ctl_reg;
    logic [1:0]         neg_reg;
    logic [1:0][W:0]    val_reg;
    logic [1:0][NW-1:0] rem_reg;
    logic [SSW-1:0]     den_reg;

    always_comb
    begin
        den_c = SSW'(sq_r_reg) + SSW'(sq_i_reg);
        unique case (func1_reg)
            FUNC_ADD, FUNC_SUB:
            begin
                s_sel[0] = SSW'(s_re_reg);
                s_sel[1] = SSW'(s_im_reg);
            end
            FUNC_MUL:
            begin
                s_sel[0] = SSW'(p_rr_reg) - SSW'(p_ii_reg);
                s_sel[1] = SSW'(p_ri_reg) + SSW'(p_ir_reg);
            end
            default:
            begin
                s_sel[0] = SSW'(p_rr_reg) + SSW'(p_ii_reg);
                s_sel[1] = SSW'(p_ir_reg) - SSW'(p_ri_reg);
            end
        endcase

        ctl_next.valid  = v1_reg;
        ctl_next.is_div = (func1_reg == FUNC_DIV) && !bz1_reg;
        ctl_next.dz     = (func1_reg == FUNC_DIV) && bz1_reg;

        for (int l = 0; l < 2; l++)
        begin
            mag[l]      = s_sel[l][SSW-1] ? SSW'(-s_sel[l]) : SSW'(s_sel[l]);
            neg_next[l] = s_sel[l][SSW-1];
            rem_next[l] = NW'(mag[l]) << F;
            unique case (func1_reg)
                FUNC_ADD, FUNC_SUB: val_next[l] = cap(mag[l]);
                FUNC_MUL:           val_next[l] = cap(mag[l] >> F);
                default:
                begin
                    // quotient of 2^W or more saturates whatever the low bits
                    if ((rem_next[l] >> W) >= NW'(den_c))
                        val_next[l] = {1'b1, {W{1'b0}}};
                    else
                        val_next[l] = '0;
                    if (bz1_reg)
                    begin
                        neg_next[l] = 1'b0;
                        val_next[l] = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg <= neg_next;
            val_reg <= val_next;
            rem_reg <= rem_next;
            den_reg <= den_c;
        end
    end

    assign ctl = ctl_reg;
    assign neg = neg_reg;
    assign val = val_reg;
    assign rem = rem_reg;
    assign den = den_reg;

endmodule

// ----- rtl/cau_div_stage.sv -----
module cau_div_stage #(
    parameter int W = 16,
    parameter int F = 12,
    parameter int K = 0,
    localparam int NW = 2*W + 1 + F
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  cau_pkg::ctl_t      ctl_in,
    input  logic [1:0]         neg_in,
    input  logic [1:0][W:0]    val_in,
    input  logic [1:0][NW-1:0] rem_in,
    input  logic [2*W:0]       den_in,
    output cau_pkg::ctl_t      ctl_out,
    output logic [1:0]         neg_out,
    output logic [1:0][W:0]    val_out,
    output logic [1:0][NW-1:0] rem_out,
    output logic [2*W:0]       den_out
);
    import cau_pkg::*;

    localparam int XW = NW + W;

    logic [1:0][W:0]    val_next;
    logic [1:0][NW-1:0] rem_next;
    ctl_t               ctl_reg;
    logic [1:0]         neg_reg;
    logic [1:0][W:0]    val_reg;
    logic [1:0][NW-1:0] rem_reg;
    logic [2*W:0]       den_reg;

    // one restoring step: quotient bit K of each lane
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            val_next[l] = val_in[l];
            rem_next[l] = rem_in[l];
            if (ctl_in.is_div && ((rem_in[l] >> K) >= NW'(den_in)))
            begin
                rem_next[l]    = NW'(XW'(rem_in[l]) - (XW'(den_in) << K));
                val_next[l][K] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (adv)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg <= neg_in;
            val_reg <= val_next;
            rem_reg <= rem_next;
            den_reg <= den_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign neg_out = neg_reg;
    assign val_out = val_reg;
    assign rem_out = rem_reg;
    assign den_out = den_reg;

endmodule

// ----- rtl/complex_arith_unit.sv -----
// Complex arithmetic unit: each request brings two complex operands in signed
// fixed point (DATA_WIDTH bits, FRAC_BITS fractional) and an operation code
// (add, subtract, multiply, divide) and yields one result with both parts
// saturated, an overflow flag and a divide-by-zero flag. The unit is a fixed
// pipeline of DATA_WIDTH + 3 register stages: products, combine/magnitude,
// one restoring quotient bit per stage for DATA_WIDTH stages, then saturation
// into the output register. Every operation takes the same path, so results
// leave in request order and one request is taken every cycle while the
// result side does not stall. When the result side stalls, the whole pipeline
// holds; nothing is dropped or repeated. Divide by zero returns zero parts,
// overflow low and div_by_zero high.
module complex_arith_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    cau_in_if.sink    operand,
    cau_out_if.source result
);
    import cau_pkg::*;

    `include "assert_macros.svh"

    localparam int W  = DATA_WIDTH;
    localparam int NW = 2*W + 1 + FRAC_BITS;

    // advance every stage unless a finished result is waiting and not taken
    logic adv;

    ctl_t               ctl_s [W+1];
    logic [1:0]         neg_s [W+1];
    logic [1:0][W:0]    val_s [W+1];
    logic [1:0][NW-1:0] rem_s [W+1];
    logic [2*W:0]       den_s [W+1];

    logic                out_valid_reg;
    logic signed [W-1:0] res_real_reg, res_imag_reg;
    logic                overflow_reg, div_by_zero_reg;

    assign adv           = !out_valid_reg || result.ready;
    assign operand.ready = adv;

    cau_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (operand.valid),
        .func     (operand.func),
        .a_real   (operand.a_real),
        .a_imag   (operand.a_imag),
        .b_real   (operand.b_real),
        .b_imag   (operand.b_imag),
        .ctl      (ctl_s[0]),
        .neg      (neg_s[0]),
        .val      (val_s[0]),
        .rem      (rem_s[0]),
        .den      (den_s[0])
    );

    // quotient bits, most significant first
    for (genvar j = 0; j < W; j++)
    begin : g_div
        cau_div_stage #(
            .W (W),
            .F (FRAC_BITS),
            .K (W - 1 - j)
        ) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .ctl_in  (ctl_s[j]),
            .neg_in  (neg_s[j]),
            .val_in  (val_s[j]),
            .rem_in  (rem_s[j]),
            .den_in  (den_s[j]),
            .ctl_out (ctl_s[j+1]),
            .neg_out (neg_s[j+1]),
            .val_out (val_s[j+1]),
            .rem_out (rem_s[j+1]),
            .den_out (den_s[j+1])
        );
    end

    // saturate sign and magnitude into the part range
    localparam logic [W:0] HALF = {2'b01, {(W-1){1'b0}}};

    logic [1:0][W-1:0] part_next;
    logic [1:0]        ovf_part;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            ovf_part[l] = 1'b0;
            if (neg_s[W][l])
            begin
                if (val_s[W][l] > HALF)
                begin
                    ovf_part[l]  = 1'b1;
                    part_next[l] = {1'b1, {(W-1){1'b0}}};
                end
                else
                begin
                    part_next[l] = W'(-val_s[W][l]);
                end
            end
            else if (val_s[W][l] > HALF - 1'b1)
            begin
                ovf_part[l]  = 1'b1;
                part_next[l] = {1'b0, {(W-1){1'b1}}};
            end
            else
            begin
                part_next[l] = val_s[W][l][W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= ctl_s[W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_real_reg    <= part_next[0];
            res_imag_reg    <= part_next[1];
            overflow_reg    <= |ovf_part;
            div_by_zero_reg <= ctl_s[W].dz;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.res_real    = res_real_reg;
    assign result.res_imag    = res_imag_reg;
    assign result.overflow    = overflow_reg;
    assign result.div_by_zero = div_by_zero_reg;

    localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

    // a zero divisor never reports saturation and gives zero parts
    `CAU_IMPLY(a_dz_zero, clk, rst_n, out_valid_reg && div_by_zero_reg,
        !overflow_reg && (res_real_reg == '0) && (res_imag_reg == '0))
    // overflow means at least one part sits at a range limit
    `CAU_IMPLY(a_ovf_limit, clk, rst_n, out_valid_reg && overflow_reg,
        (res_real_reg == SMAX) || (res_real_reg == SMIN) || (res_imag_reg == SMAX) || (res_imag_reg == SMIN))
    // divide control bits are exclusive along the pipe
    `CAU_ASSERT(a_ctl_excl, clk, rst_n, !(ctl_s[W].is_div && ctl_s[W].dz))

endmodule
